FILE: rtl/core/bftm_pkg.sv
// shared types, constants and codes of the tape machine core
package bftm_pkg;

  localparam int unsigned TapeCells = 32768;
  localparam int unsigned ProgDepth = 4096;

  localparam int unsigned TpW   = $clog2(TapeCells);
  localparam int unsigned PaW   = $clog2(ProgDepth);
  localparam int unsigned PcW   = PaW + 1;
  localparam int unsigned BalW  = PcW + 1;
  localparam int unsigned StepW = 24;

  localparam logic [StepW-1:0] StepLimitReset = 24'd10000000;

  // request modes
  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModeStep  = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  // status codes
  localparam logic [2:0] StRunning  = 3'd0;
  localparam logic [2:0] StFinished = 3'd1;
  localparam logic [2:0] StUnmatch  = 3'd2;
  localparam logic [2:0] StStepLim  = 3'd3;
  localparam logic [2:0] StTapeOver = 3'd4;
  localparam logic [2:0] StTapeUnd  = 3'd5;
  localparam logic [2:0] StFull     = 3'd6;
  localparam logic [2:0] StScanOut  = 3'd7;

  // instruction characters
  localparam logic [7:0] ChInc   = 8'h2B;
  localparam logic [7:0] ChDec   = 8'h2D;
  localparam logic [7:0] ChRight = 8'h3E;
  localparam logic [7:0] ChLeft  = 8'h3C;
  localparam logic [7:0] ChOut   = 8'h2E;
  localparam logic [7:0] ChIn    = 8'h2C;
  localparam logic [7:0] ChOpen  = 8'h5B;
  localparam logic [7:0] ChClose = 8'h5D;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] program_byte;
  } in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic [2:0] status;
  } out_t;

  typedef struct packed {
    logic           we;
    logic [PaW-1:0] waddr;
    logic [7:0]     wdata;
    logic [PaW-1:0] raddr;
  } prog_req_t;

  typedef struct packed {
    logic           we;
    logic [TpW-1:0] waddr;
    logic [7:0]     wdata;
    logic [TpW-1:0] raddr;
  } tape_req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_COMMA,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RESULT
  } state_e;

endpackage

FILE: rtl/core/bftm_ram.sv
// generic single write port ram with registered read
module bftm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/core/bftm_exec.sv
// instruction sequencer: machine registers and read-modify-write of both memories
module bftm_exec (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bftm_pkg::StepW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bftm_pkg::in_t                in_data_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output bftm_pkg::out_t               res_o,
  output bftm_pkg::prog_req_t          prog_req_o,
  input  logic [7:0]                   prog_rdata_i,
  output bftm_pkg::tape_req_t          tape_req_o,
  input  logic [7:0]                   tape_rdata_i
);

  localparam int unsigned PcW  = bftm_pkg::PcW;
  localparam int unsigned PaW  = bftm_pkg::PaW;
  localparam int unsigned TpW  = bftm_pkg::TpW;
  localparam int unsigned BalW = bftm_pkg::BalW;

  bftm_pkg::state_e state_q, state_d;

  logic [bftm_pkg::StepW-1:0] limit_q, limit_d;
  logic [bftm_pkg::StepW-1:0] steps_q, steps_d;
  logic [PcW-1:0]             cnt_q, cnt_d;
  logic [BalW-1:0]            bal_q, bal_d;
  logic [TpW-1:0]             tp_q, tp_d;
  logic [PcW-1:0]             ip_q, ip_d;
  logic [2:0]                 halt_q, halt_d;
  logic [PcW-1:0]             pos_q, pos_d;
  logic [PcW:0]               depth_q, depth_d;
  logic                       fwd_q, fwd_d;
  logic [TpW-1:0]             clr_q, clr_d;
  logic                       clr_res_q, clr_res_d;
  bftm_pkg::out_t             res_q, res_d;

  logic           accept;
  logic [2:0]     pre_halt;
  logic [PcW-1:0] ip_inc1, ip_inc2, pos_next, pos_inc1;
  logic           scan_fail;
  logic [7:0]     open_ch, close_ch;
  logic           clr_last;

  function automatic logic [2:0] fin_code(logic [PcW-1:0] nip, logic [PcW-1:0] cnt);
    fin_code = (nip >= cnt) ? bftm_pkg::StFinished : bftm_pkg::StRunning;
  endfunction

  // shared decode
  always_comb begin
    accept   = in_valid_i && (state_q == bftm_pkg::S_IDLE);
    ip_inc1  = ip_q + PcW'(1);
    ip_inc2  = ip_q + PcW'(2);
    pos_inc1 = pos_q + PcW'(1);
    pos_next = fwd_q ? pos_inc1 : (pos_q - PcW'(1));
    scan_fail = fwd_q ? (pos_inc1 >= cnt_q) : (pos_q == '0);
    open_ch  = fwd_q ? bftm_pkg::ChOpen : bftm_pkg::ChClose;
    close_ch = fwd_q ? bftm_pkg::ChClose : bftm_pkg::ChOpen;
    clr_last = (clr_q == TpW'(bftm_pkg::TapeCells - 1));
    if (bal_q != '0) begin
      pre_halt = bftm_pkg::StUnmatch;
    end else if (ip_q >= cnt_q) begin
      pre_halt = bftm_pkg::StFinished;
    end else if (steps_q >= limit_q) begin
      pre_halt = bftm_pkg::StStepLim;
    end else begin
      pre_halt = bftm_pkg::StRunning;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bftm_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_d = clr_res_q ? bftm_pkg::S_RESULT : bftm_pkg::S_IDLE;
        end
      end
      bftm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.mode == bftm_pkg::ModeClear) begin
            state_d = bftm_pkg::S_CLEAR;
          end else if (in_data_i.mode == bftm_pkg::ModeStep &&
                       halt_q == bftm_pkg::StRunning &&
                       pre_halt == bftm_pkg::StRunning) begin
            state_d = bftm_pkg::S_EXEC;
          end else begin
            state_d = bftm_pkg::S_RESULT;
          end
        end
      end
      bftm_pkg::S_EXEC: begin
        if (prog_rdata_i == bftm_pkg::ChIn && ip_inc1 < cnt_q) begin
          state_d = bftm_pkg::S_COMMA;
        end else if ((prog_rdata_i == bftm_pkg::ChOpen && tape_rdata_i == '0) ||
                     (prog_rdata_i == bftm_pkg::ChClose && tape_rdata_i != '0)) begin
          state_d = bftm_pkg::S_SCAN_RD;
        end else begin
          state_d = bftm_pkg::S_RESULT;
        end
      end
      bftm_pkg::S_COMMA: state_d = bftm_pkg::S_RESULT;
      bftm_pkg::S_SCAN_RD: state_d = scan_fail ? bftm_pkg::S_RESULT : bftm_pkg::S_SCAN_CHK;
      bftm_pkg::S_SCAN_CHK: begin
        if (prog_rdata_i == close_ch && depth_q == (PcW+1)'(1)) begin
          state_d = bftm_pkg::S_RESULT;
        end else begin
          state_d = bftm_pkg::S_SCAN_RD;
        end
      end
      bftm_pkg::S_RESULT: begin
        if (res_ready_i) begin
          state_d = bftm_pkg::S_IDLE;
        end
      end
      default: state_d = bftm_pkg::S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    limit_d   = cfg_we_i ? cfg_wdata_i : limit_q;
    steps_d   = steps_q;
    cnt_d     = cnt_q;
    bal_d     = bal_q;
    tp_d      = tp_q;
    ip_d      = ip_q;
    halt_d    = halt_q;
    pos_d     = pos_q;
    depth_d   = depth_q;
    fwd_d     = fwd_q;
    clr_d     = clr_q;
    clr_res_d = clr_res_q;
    res_d     = res_q;

    prog_req_o.we    = 1'b0;
    prog_req_o.waddr = cnt_q[PaW-1:0];
    prog_req_o.wdata = in_data_i.program_byte;
    prog_req_o.raddr = ip_q[PaW-1:0];
    tape_req_o.we    = 1'b0;
    tape_req_o.waddr = tp_q;
    tape_req_o.wdata = '0;
    tape_req_o.raddr = tp_q;

    in_ready_o  = (state_q == bftm_pkg::S_IDLE);
    res_valid_o = (state_q == bftm_pkg::S_RESULT);

    unique case (state_q)
      bftm_pkg::S_CLEAR: begin
        tape_req_o.we    = 1'b1;
        tape_req_o.waddr = clr_q;
        clr_d            = clr_q + TpW'(1);
      end
      bftm_pkg::S_IDLE: begin
        if (accept) begin
          res_d.out_valid = 1'b0;
          res_d.out_byte  = '0;
          res_d.status    = halt_q;
          case (in_data_i.mode)
            bftm_pkg::ModeLoad: begin
              if (cnt_q[PaW]) begin
                res_d.status = bftm_pkg::StFull;
              end else begin
                prog_req_o.we = 1'b1;
                cnt_d = cnt_q + PcW'(1);
                if (in_data_i.program_byte == bftm_pkg::ChOpen) begin
                  bal_d = bal_q + BalW'(1);
                end else if (in_data_i.program_byte == bftm_pkg::ChClose) begin
                  bal_d = bal_q - BalW'(1);
                end
              end
            end
            bftm_pkg::ModeStep: begin
              if (halt_q == bftm_pkg::StRunning) begin
                if (pre_halt != bftm_pkg::StRunning) begin
                  halt_d       = pre_halt;
                  res_d.status = pre_halt;
                end else begin
                  steps_d = steps_q + bftm_pkg::StepW'(1);
                end
              end
            end
            bftm_pkg::ModeClear: begin
              cnt_d        = '0;
              bal_d        = '0;
              tp_d         = '0;
              ip_d         = '0;
              steps_d      = '0;
              halt_d       = bftm_pkg::StRunning;
              clr_d        = '0;
              clr_res_d    = 1'b1;
              res_d.status = bftm_pkg::StRunning;
            end
            default: ;
          endcase
        end
      end
      bftm_pkg::S_EXEC: begin
        prog_req_o.raddr = ip_inc1[PaW-1:0];
        ip_d   = ip_inc1;
        halt_d = fin_code(ip_inc1, cnt_q);
        case (prog_rdata_i)
          bftm_pkg::ChInc: begin
            tape_req_o.we    = 1'b1;
            tape_req_o.wdata = tape_rdata_i + 8'd1;
          end
          bftm_pkg::ChDec: begin
            tape_req_o.we    = 1'b1;
            tape_req_o.wdata = tape_rdata_i - 8'd1;
          end
          bftm_pkg::ChRight: begin
            if (tp_q == TpW'(bftm_pkg::TapeCells - 1)) begin
              ip_d   = ip_q;
              halt_d = bftm_pkg::StTapeOver;
            end else begin
              tp_d = tp_q + TpW'(1);
            end
          end
          bftm_pkg::ChLeft: begin
            if (tp_q == '0) begin
              ip_d   = ip_q;
              halt_d = bftm_pkg::StTapeUnd;
            end else begin
              tp_d = tp_q - TpW'(1);
            end
          end
          bftm_pkg::ChOut: begin
            res_d.out_valid = 1'b1;
            res_d.out_byte  = tape_rdata_i;
          end
          bftm_pkg::ChIn: begin
            if (ip_inc1 < cnt_q) begin
              ip_d   = ip_q;
              halt_d = halt_q;
            end else begin
              // comma at the end of the program reads zero
              tape_req_o.we = 1'b1;
              ip_d   = ip_inc2;
              halt_d = fin_code(ip_inc2, cnt_q);
            end
          end
          bftm_pkg::ChOpen, bftm_pkg::ChClose: begin
            if ((prog_rdata_i == bftm_pkg::ChOpen) == (tape_rdata_i == '0)) begin
              ip_d    = ip_q;
              halt_d  = halt_q;
              pos_d   = ip_q;
              depth_d = (PcW+1)'(1);
              fwd_d   = (prog_rdata_i == bftm_pkg::ChOpen);
            end
          end
          default: ;
        endcase
        res_d.status = halt_d;
      end
      bftm_pkg::S_COMMA: begin
        tape_req_o.we    = 1'b1;
        tape_req_o.wdata = prog_rdata_i;
        ip_d         = ip_inc2;
        halt_d       = fin_code(ip_inc2, cnt_q);
        res_d.status = halt_d;
      end
      bftm_pkg::S_SCAN_RD: begin
        prog_req_o.raddr = pos_next[PaW-1:0];
        if (scan_fail) begin
          halt_d       = bftm_pkg::StScanOut;
          res_d.status = bftm_pkg::StScanOut;
        end else begin
          pos_d = pos_next;
        end
      end
      bftm_pkg::S_SCAN_CHK: begin
        if (prog_rdata_i == open_ch) begin
          depth_d = depth_q + (PcW+1)'(1);
        end else if (prog_rdata_i == close_ch) begin
          if (depth_q == (PcW+1)'(1)) begin
            ip_d         = pos_inc1;
            halt_d       = fin_code(pos_inc1, cnt_q);
            res_d.status = halt_d;
          end else begin
            depth_d = depth_q - (PcW+1)'(1);
          end
        end
      end
      bftm_pkg::S_RESULT: begin
        if (res_ready_i) begin
          clr_res_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bftm_pkg::S_CLEAR;
      limit_q   <= bftm_pkg::StepLimitReset;
      steps_q   <= '0;
      cnt_q     <= '0;
      bal_q     <= '0;
      tp_q      <= '0;
      ip_q      <= '0;
      halt_q    <= bftm_pkg::StRunning;
      clr_q     <= '0;
      clr_res_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      limit_q   <= limit_d;
      steps_q   <= steps_d;
      cnt_q     <= cnt_d;
      bal_q     <= bal_d;
      tp_q      <= tp_d;
      ip_q      <= ip_d;
      halt_q    <= halt_d;
      clr_q     <= clr_d;
      clr_res_q <= clr_res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    depth_q <= depth_d;
    fwd_q   <= fwd_d;
    res_q   <= res_d;
  end

endmodule

FILE: rtl/core/bf_tape_machine_core_unit.sv
// top level of the tape machine core: memories, sequencer and output register
//
// Brainfuck-style tape machine. A request in load mode appends a program
// byte, step mode executes one instruction, clear mode empties program and
// tape; every request gives exactly one result with out_valid, out_byte and
// status. Program bytes and tape cells sit in two synchronous RAMs and each
// instruction is a read-modify-write through them, so the rate is set by the
// single read port of each RAM: a load, a mode 3 request or a step that does
// not execute goes from idle straight to result, an instruction through the
// execute state, a comma also through the comma state unless it is the last
// byte, a scanning bracket through scan read and scan check for each byte it
// walks, ending in scan read if it runs off either end. After reset and each
// clear the tape is zeroed one cell a cycle, all TapeCells (32768), with no
// request taken meanwhile; a clear's result comes once that pass is over.
// The user must write step_limit via cfg_we_i and cfg_wdata_i while idle;
// the block does not enforce it. While out_stall_i is high a result waits
// in the output register and one more request is taken and run behind it.
module bf_tape_machine_core_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bftm_pkg::StepW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bftm_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bftm_pkg::out_t             out_data_o
);

  logic                in_ready;
  logic                res_valid;
  logic                res_ready;
  bftm_pkg::out_t      res;
  bftm_pkg::prog_req_t prog_req;
  bftm_pkg::tape_req_t tape_req;
  logic [7:0]          prog_rdata;
  logic [7:0]          tape_rdata;

  logic                out_vld_q, out_vld_d;
  bftm_pkg::out_t      out_q, out_d;

  // instruction sequencer
  bftm_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .prog_req_o  (prog_req),
    .prog_rdata_i(prog_rdata),
    .tape_req_o  (tape_req),
    .tape_rdata_i(tape_rdata)
  );

  // program store, contents undefined until loaded
  bftm_ram #(
    .Width(8),
    .Depth(bftm_pkg::ProgDepth)
  ) u_prog_ram (
    .clk_i  (clk_i),
    .we_i   (prog_req.we),
    .waddr_i(prog_req.waddr),
    .wdata_i(prog_req.wdata),
    .raddr_i(prog_req.raddr),
    .rdata_o(prog_rdata)
  );

  // tape, zeroed by the clearing pass
  bftm_ram #(
    .Width(8),
    .Depth(bftm_pkg::TapeCells)
  ) u_tape_ram (
    .clk_i  (clk_i),
    .we_i   (tape_req.we),
    .waddr_i(tape_req.waddr),
    .wdata_i(tape_req.wdata),
    .raddr_i(tape_req.raddr),
    .rdata_o(tape_rdata)
  );

  assign in_stall_o = !in_ready;

  // output register frees up when empty or when its result is taken
  assign res_ready = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (res_ready) begin
      out_vld_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
